[rtl/core/msqd_pkg.sv]
`timescale 1ns / 1ps
package msqd_pkg;

    localparam int RepeatSlots = 16;
    localparam int SlotBits    = $clog2(RepeatSlots);
    localparam logic [16:0] Sat17     = 17'h1FFFF;
    localparam logic [15:0] AddrLimit = 16'h8000;

    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_CHANNEL = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        next_address;
        logic               note_valid;
        logic signed [11:0] note_number;
        logic [10:0]        note_length;
        logic [16:0]        note_delay;
        logic               first_note;
        logic               tempo_valid;
        logic [7:0]         tempo_code;
        logic [16:0]        tempo_delay;
        logic               channel_done;
    } t_out_item;

    function automatic logic [7:0] len_lookup(input logic [11:0] idx);
        logic [7:0] v;
        case (idx)
            12'd3: v = 8'h04;  12'd4: v = 8'h08;  12'd5: v = 8'h10;
            12'd6: v = 8'h20;  12'd7: v = 8'h40;  12'd8: v = 8'h18;
            12'd9: v = 8'h02;  12'd10: v = 8'h0E; 12'd11: v = 8'h04;
            12'd12: v = 8'h08; 12'd13: v = 8'h10; 12'd14: v = 8'h20;
            12'd15: v = 8'h40; 12'd19: v = 8'h01; 12'd20: v = 8'h02;
            12'd21: v = 8'h03; 12'd22: v = 8'h04; 12'd23: v = 8'h05;
            12'd24, 12'd25, 12'd26, 12'd27,
            12'd28, 12'd29, 12'd30, 12'd31: v = 8'h08;
            12'd35: v = 8'h01; 12'd36: v = 8'h01; 12'd37: v = 8'h02;
            12'd38: v = 8'h02; 12'd39: v = 8'h02; 12'd40: v = 8'h04;
            12'd42: v = 8'h03; 12'd43: v = 8'h02; 12'd44: v = 8'h03;
            12'd45: v = 8'h04; 12'd46: v = 8'h05; 12'd47: v = 8'h06;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] sat_add17(input logic [16:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[17] ? Sat17 : s[16:0];
    endfunction

endpackage

[rtl/core/music_sequence_command_decoder.sv]
`timescale 1ns / 1ps
// Decodes one sound-driver command per item. An item is taken while the repeat table (a
// 16-entry synchronous memory) is read at its slot; once the output register is free, the
// command is decoded, the state and the repeat entry are written back and the result loads the
// output register. The input is ready whenever no command is being decoded, so a new item may
// enter while the result waits in the output register; its decode then holds until that result
// is taken. Repeat arming keeps the fetch address, so the same command comes back and jumps on
// its second read unless the armed count is zero. Write configuration only while no item is in
// flight.
module music_sequence_command_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  msqd_pkg::t_in_item        i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output msqd_pkg::t_out_item       o_item,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [16:0]               i_cfg_data
);

    localparam int SB = msqd_pkg::SlotBits;

    // repeat table: count (5 bits, all ones = unarmed) and address
    logic [20:0] rep_mem [msqd_pkg::RepeatSlots];
    logic [20:0] r_rep_rd;
    logic [msqd_pkg::RepeatSlots-1:0] r_rep_init;  // entry written since reset

    logic               r_version;
    logic [1:0]         r_channel;
    logic [16:0]        r_limit;
    logic [15:0]        r_pos;
    logic               r_ended, r_first;
    logic signed [7:0]  r_transpose;
    logic [9:0]         r_base;
    logic [10:0]        r_len_base, r_cur_len;
    logic [16:0]        r_pend, r_tst;
    logic [1:0]         r_depth;
    logic [15:0]        r_mtgt [3];
    logic [15:0]        r_mret [3];

    logic               r_busy;
    msqd_pkg::t_in_item r_cmd;
    logic               r_out_valid;
    msqd_pkg::t_out_item r_out;

    logic [SB-1:0] rd_slot;
    assign rd_slot = i_item.byte1[7:4];

    logic accept, fire;
    assign o_ready = !r_busy;
    assign accept  = i_valid && o_ready;
    // finish the decode only when the output register is free
    assign fire    = r_busy && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // decode
    logic [7:0] b0, b1, b2, b3;
    assign b0 = r_cmd.byte0;
    assign b1 = r_cmd.byte1;
    assign b2 = r_cmd.byte2;
    assign b3 = r_cmd.byte3;

    logic [SB-1:0] slot;
    assign slot = b1[7:4];
    logic [4:0]  rep_cnt;
    logic [15:0] rep_addr;
    assign rep_cnt  = r_rep_init[slot] ? r_rep_rd[20:16] : 5'h1F;
    assign rep_addr = r_rep_init[slot] ? r_rep_rd[15:0] : 16'd0;

    msqd_pkg::t_out_item res;
    logic [15:0] n_pos;
    logic n_ended, n_first;
    logic signed [7:0] n_transpose;
    logic [9:0]  n_base;
    logic [10:0] n_len_base, n_cur_len;
    logic [16:0] n_pend, n_tst;
    logic [1:0]  n_depth;
    logic        push, rep_we;
    logic [20:0] rep_wd;

    logic [11:0] len_idx;
    logic [10:0] tab_len, note_len;
    logic signed [11:0] note;
    logic        emit_n, emit_t, do_rep;
    logic [8:0]  tr_sum;
    logic [15:0] tgt;

    always_comb begin
        res = '0;
        n_pos = r_pos; n_ended = r_ended; n_first = r_first;
        n_transpose = r_transpose; n_base = r_base; n_len_base = r_len_base;
        n_cur_len = r_cur_len; n_pend = r_pend; n_tst = r_tst; n_depth = r_depth;
        push = 1'b0; rep_we = 1'b0; rep_wd = '0;
        emit_n = 1'b0; emit_t = 1'b0; do_rep = 1'b0;
        note = '0; note_len = '0;
        len_idx = 12'(b0[7:5]) + 12'(r_len_base);
        tab_len = 11'(msqd_pkg::len_lookup(len_idx)) * 11'd5;
        tr_sum = 9'(signed'(r_transpose)) + 9'(signed'(b1));
        tgt = {b2, b1};

        if (!r_ended && (r_tst >= r_limit || r_pos >= msqd_pkg::AddrLimit))
            n_ended = 1'b1;
        if (!n_ended) begin
            if (!r_version) begin
                if (b0 == 8'hFF) begin
                    n_ended = 1'b1;
                end else if (b0[4:0] == 5'h1E) begin
                    n_pos = r_pos + 16'd1;
                end else if (b0[4:0] == 5'h1F) begin
                    case (b0[7:5])
                        3'd0: begin n_base = {b1, 2'b00}; n_pos = r_pos + 16'd2; end
                        3'd1: begin n_len_base = {b3, 3'b000}; n_pos = r_pos + 16'd5; end
                        3'd2: begin emit_t = 1'b1; n_pos = r_pos + 16'd2; end
                        3'd3: n_ended = 1'b1;
                        3'd4: do_rep = 1'b1;
                        default: n_pos = r_pos + 16'd1;
                    endcase
                end else begin
                    n_cur_len = tab_len;
                    n_pos = r_pos + 16'd1;
                    if (b0[4:0] == 5'd0) begin
                        n_pend = msqd_pkg::sat_add17(r_pend, 17'(tab_len));
                    end else begin
                        note = 12'(r_base) + 12'(b0[4:0]) + 12'sd24
                            - ((r_channel == 2'd2) ? 12'sd12 : 12'sd0);
                        note_len = tab_len;
                        emit_n = 1'b1;
                    end
                end
            end else if (b0 <= 8'hBF) begin
                note = 12'(b0[5:0]) + 12'sd21 + 12'(r_transpose);
                if (r_channel == 2'd3 && note >= 12'sd36) note = note - 12'sd36;
                if (b0 <= 8'h3F) begin
                    n_pos = r_pos + 16'd1;
                end else if (b0 <= 8'h7F) begin
                    if (b1[7]) begin
                        n_cur_len = 11'(b2) * 11'd5; n_pos = r_pos + 16'd3;
                    end else begin
                        n_pos = r_pos + 16'd2;
                    end
                end else begin
                    n_cur_len = 11'(b1) * 11'd5; n_pos = r_pos + 16'd2;
                end
                note_len = n_cur_len;
                emit_n = 1'b1;
            end else begin
                case (b0)
                    8'hC2: begin n_transpose = b1; n_pos = r_pos + 16'd2; end
                    8'hC3: begin emit_t = 1'b1; n_pos = r_pos + 16'd2; end
                    8'hC5: begin
                        if (r_depth == 2'd3 ||
                            (r_depth != 2'd0 && r_mtgt[r_depth - 2'd1] == tgt)) begin
                            n_ended = 1'b1;
                        end else begin
                            push = 1'b1; n_depth = r_depth + 2'd1; n_pos = tgt;
                        end
                    end
                    8'hC6: begin
                        if (r_depth != 2'd0) begin
                            n_depth = r_depth - 2'd1; n_pos = r_mret[r_depth - 2'd1];
                        end else begin
                            n_pos = r_pos + 16'd1;
                        end
                    end
                    8'hC7: do_rep = 1'b1;
                    8'hCF: begin
                        n_pend = msqd_pkg::sat_add17(r_pend, 17'(b1) * 17'd5);
                        n_tst  = msqd_pkg::sat_add17(r_tst, 17'(b1) * 17'd5);
                        n_pos = r_pos + 16'd2;
                    end
                    8'hD0: begin
                        if ($signed(tr_sum) > 9'sd127) n_transpose = 8'sd127;
                        else if ($signed(tr_sum) < -9'sd128) n_transpose = -8'sd128;
                        else n_transpose = tr_sum[7:0];
                        n_pos = r_pos + 16'd2;
                    end
                    8'hDC: begin n_transpose = b3; n_pos = r_pos + 16'd5; end
                    8'hFF: n_ended = 1'b1;
                    8'hC0, 8'hC1, 8'hC4, 8'hC9, 8'hD2, 8'hD3, 8'hD4, 8'hD9:
                        n_pos = r_pos + 16'd2;
                    default: n_pos = r_pos + 16'd1;
                endcase
            end

            if (do_rep) begin
                rep_we = 1'b1;
                if (rep_cnt == 5'h1F) begin
                    rep_wd = {1'b0, b1[3:0], b3, b2};
                end else if (rep_cnt != 5'd0) begin
                    rep_wd = {rep_cnt - 5'd1, rep_addr};
                    n_pos = rep_addr;
                end else begin
                    rep_wd = {5'h1F, rep_addr};
                    n_pos = r_pos + 16'd4;
                end
            end
            if (emit_n) begin
                res.note_valid = 1'b1;
                res.note_number = note;
                res.note_length = note_len;
                res.note_delay = r_pend;
                res.first_note = r_first;
                n_first = 1'b0;
                n_pend = '0;
                n_tst = msqd_pkg::sat_add17(r_tst, 17'(note_len));
            end
            if (emit_t) begin
                res.tempo_valid = 1'b1;
                res.tempo_code = b1;
                res.tempo_delay = r_tst;
                n_tst = '0;
            end
            if (!n_ended && (n_tst >= r_limit || n_pos >= msqd_pkg::AddrLimit))
                n_ended = 1'b1;
        end else begin
            n_pos = r_pos;
        end
        res.next_address = n_pos;
        res.channel_done = n_ended;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_rep_rd <= rep_mem[rd_slot];
        if (fire && rep_we) rep_mem[slot] <= rep_wd;
        if (accept) r_cmd <= i_item;
        if (fire) begin
            r_out <= res;
            if (push) begin
                r_mtgt[r_depth] <= tgt;
                r_mret[r_depth] <= r_pos + 16'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= 1'b1; r_channel <= '0; r_limit <= 17'd110000;
            r_pos <= '0; r_ended <= 1'b1; r_first <= 1'b1; r_transpose <= '0;
            r_base <= '0; r_len_base <= '0; r_cur_len <= '0; r_pend <= '0;
            r_tst <= '0; r_depth <= '0; r_rep_init <= '0;
            r_busy <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            if (fire) r_out_valid <= 1'b1;
            else if (o_valid && i_ready) r_out_valid <= 1'b0;
            if (accept) r_busy <= 1'b1;
            else if (fire) r_busy <= 1'b0;
            if (fire) begin
                r_pos <= n_pos; r_ended <= n_ended; r_first <= n_first;
                r_transpose <= n_transpose; r_base <= n_base;
                r_len_base <= n_len_base; r_cur_len <= n_cur_len;
                r_pend <= n_pend; r_tst <= n_tst; r_depth <= n_depth;
                if (rep_we) r_rep_init[slot] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    msqd_pkg::REG_VERSION: r_version <= i_cfg_data[0];
                    msqd_pkg::REG_CHANNEL: r_channel <= i_cfg_data[1:0];
                    msqd_pkg::REG_START: begin
                        r_pos <= i_cfg_data[15:0];
                        r_ended <= (i_cfg_data[15:0] == 16'd0);
                        r_first <= 1'b1; r_transpose <= '0; r_base <= '0;
                        r_cur_len <= '0; r_pend <= '0; r_tst <= '0; r_depth <= '0;
                    end
                    msqd_pkg::REG_LIMIT: r_limit <= i_cfg_data;
                    default: r_limit <= r_limit;
                endcase
            end
        end
    end

endmodule
